@@ design/itdt_pkg.sv @@
// ----------------------------------------------------------------------------
// itdt_pkg
// Shared types and character codes for the integer to decimal text block.
// ----------------------------------------------------------------------------
package itdt_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_out_char;

endpackage

@@ design/itdt_front.sv @@
// ----------------------------------------------------------------------------
// itdt_front
// Holds the signed mode register, classifies each accepted word as negative
// or not and forms its unsigned magnitude for the conversion queue.
// ----------------------------------------------------------------------------
module itdt_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_wr_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [VALUE_BITS-1:0] i_value_word,
    output logic                  o_push,
    input  logic                  i_q_ready,
    output logic                  o_neg,
    output logic [VALUE_BITS-1:0] o_mag
);

    logic r_signed_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_signed_mode <= i_cfg_wr_data;
        end
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;
    assign o_neg   = r_signed_mode && i_value_word[VALUE_BITS-1];
    assign o_mag   = o_neg ? (~i_value_word + VALUE_BITS'(1)) : i_value_word;

endmodule

@@ design/itdt_queue.sv @@
// ----------------------------------------------------------------------------
// itdt_queue
// Two-entry queue that decouples classification from conversion.
// ----------------------------------------------------------------------------
module itdt_queue #(
    parameter int DATA_BITS = 33
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_BITS-1:0] i_data,
    output logic                 o_ready,
    input  logic                 i_pop,
    output logic                 o_valid,
    output logic [DATA_BITS-1:0] o_data
);

    logic [DATA_BITS-1:0] r_mem [2];
    logic                 r_wr_ptr;
    logic                 r_rd_ptr;
    logic [1:0]           r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ design/itdt_back.sv @@
// ----------------------------------------------------------------------------
// itdt_back
// Bit-serial binary to BCD conversion, leading zero removal and character
// output through a registered output stage.
// ----------------------------------------------------------------------------
module itdt_back #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    output logic                  o_q_pop,
    input  logic                  i_neg,
    input  logic [VALUE_BITS-1:0] i_mag,
    output logic                  o_valid,
    input  logic                  i_ready,
    output itdt_pkg::t_out_char   o_char
);

    import itdt_pkg::*;

    localparam int ND = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int CW = $clog2(VALUE_BITS);
    localparam int LW = $clog2(ND + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_EMIT
    } t_state;

    t_state                r_state;
    logic [VALUE_BITS-1:0] r_bin;
    logic [ND*4-1:0]       r_bcd;
    logic                  r_neg;
    logic [CW-1:0]         r_cnt;
    logic [LW-1:0]         r_left;
    logic                  r_out_valid;
    t_out_char             r_out;
    logic [ND*4-1:0]       n_bcd;
    logic [3:0]            w_top;
    logic                  w_free;

    always_comb begin
        logic [3:0]      v_d;
        logic [ND*4-1:0] v_adj;
        v_adj = '0;
        for (int i = 0; i < ND; i++) begin
            v_d = r_bcd[4*i +: 4];
            v_adj[4*i +: 4] = (v_d >= 4'd5) ? (v_d + 4'd3) : v_d;
        end
        n_bcd = {v_adj[ND*4-2:0], r_bin[VALUE_BITS-1]};
    end

    assign w_top   = r_bcd[ND*4-1 -: 4];
    assign w_free  = !r_out_valid || i_ready;
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign o_valid = r_out_valid;
    assign o_char  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ready && r_state != S_SIGN && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_bin   <= i_mag;
                        r_neg   <= i_neg;
                        r_bcd   <= '0;
                        r_cnt   <= '0;
                        r_left  <= LW'(ND);
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_bcd <= n_bcd;
                    r_bin <= {r_bin[VALUE_BITS-2:0], 1'b0};
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(VALUE_BITS - 1)) begin
                        r_state <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    if (w_top == 4'd0 && r_left > LW'(1)) begin
                        r_bcd  <= {r_bcd[ND*4-5:0], 4'd0};
                        r_left <= r_left - LW'(1);
                    end else begin
                        r_state <= r_neg ? S_SIGN : S_EMIT;
                    end
                end
                S_SIGN: begin
                    if (w_free) begin
                        r_out_valid     <= 1'b1;
                        r_out.character <= CHAR_MINUS;
                        r_out.last      <= 1'b0;
                        r_state         <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_free) begin
                        r_out_valid     <= 1'b1;
                        r_out.character <= CHAR_ZERO + {4'd0, w_top};
                        r_out.last      <= (r_left == LW'(1));
                        r_bcd           <= {r_bcd[ND*4-5:0], 4'd0};
                        r_left          <= r_left - LW'(1);
                        if (r_left == LW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_emit_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_left != '0))
        else $error("Digit emission started with no digits left.");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.character == CHAR_MINUS) |-> !r_out.last)
        else $error("Minus sign was flagged as the final character.");

    a_emit_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_free) |-> (w_top <= 4'd9))
        else $error("Converted digit is outside the decimal range.");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_free && r_left == LW'(1)) |=> (r_state == S_IDLE))
        else $error("Back end did not return to idle after the final character.");

endmodule

@@ design/integer_to_decimal_text.sv @@
// ----------------------------------------------------------------------------
// integer_to_decimal_text
// Converts one integer word per input transfer into its decimal ASCII text,
// one character per output transfer, most significant digit first.
// ----------------------------------------------------------------------------
// Each word is read as unsigned, or as two's complement when the signed mode
// bit is set, and produces a leading '-' for negative values followed by the
// digits without leading zeros; o_last marks the final character. Once the
// converter takes a word from its two-entry input queue it loads the word,
// runs the bit-serial BCD shift loop over all VALUE_BITS bits, drops the
// leading zeros one digit at a time and then sends its characters; it takes
// the next word from the queue only once the last character is registered.
// Output stalls hold the converter in place while it sends characters.
module integer_to_decimal_text #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_wr_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [VALUE_BITS-1:0] i_value_word,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_character,
    output logic                  o_last
);

    import itdt_pkg::*;

    logic                  w_push;
    logic                  w_q_ready;
    logic                  w_neg;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_q_valid;
    logic                  w_q_pop;
    logic [VALUE_BITS:0]   w_q_data;
    t_out_char             w_char;

    itdt_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value_word  (i_value_word),
        .o_push        (w_push),
        .i_q_ready     (w_q_ready),
        .o_neg         (w_neg),
        .o_mag         (w_mag)
    );

    itdt_queue #(
        .DATA_BITS (VALUE_BITS + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_neg, w_mag}),
        .o_ready (w_q_ready),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    itdt_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_q_pop),
        .i_neg     (w_q_data[VALUE_BITS]),
        .i_mag     (w_q_data[VALUE_BITS-1:0]),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_char    (w_char)
    );

    assign o_character = w_char.character;
    assign o_last      = w_char.last;

endmodule

@@ tb/integer_to_decimal_text_tb.sv @@
// ----------------------------------------------------------------------------
// integer_to_decimal_text_tb
// Self-checking testbench for the integer to decimal text converter.
// ----------------------------------------------------------------------------
// A short table of directed words covers zero, single digits, the unsigned
// and signed extremes and the most negative value. Random words follow, with
// most of them drawn near digit-count and sign boundaries. Every accepted
// word queues its expected characters from a local predictor, or from text
// typed into the table. Each output transfer is checked against the oldest
// entry. Both sides stall at random, and once the receiver holds off long
// enough to back up the input.
// ----------------------------------------------------------------------------
module integer_to_decimal_text_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itdt_pkg::*;

    localparam int VALUE_BITS    = 32;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 50;
    localparam int DIR_ROWS      = 16;
    localparam int PHASE_ITEMS   = 120;

    typedef struct {
        logic            mode;
        logic [31:0]     word;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic                  i_cfg_wr_data;
    logic                  i_valid;
    logic                  o_ready;
    logic [VALUE_BITS-1:0] i_value_word;
    logic                  o_valid;
    logic                  i_ready;
    logic [7:0]            o_character;
    logic                  o_last;

    t_out_char pending_chars[$];
    t_out_char next_char;
    logic      signed_mode_q;
    int        error_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_req;
    int        stall_cycles;

    t_dir_row  dir_rows [DIR_ROWS];
    string     dir_text [DIR_ROWS];

    integer_to_decimal_text #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value_word  (i_value_word),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_character   (o_character),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void queue_decimal_text(input logic [31:0] word, input logic mode);
        logic [31:0] mag;
        logic        neg;
        logic [3:0]  digs [10];
        int          nd;
        t_out_char   c;
        neg = mode && word[31];
        mag = neg ? (32'd0 - word) : word;
        nd = 0;
        do begin
            digs[nd] = 4'(mag % 32'd10);
            nd++;
            mag = mag / 32'd10;
        end while (mag != 0);
        if (neg) begin
            c.character = CHAR_MINUS;
            c.last = 1'b0;
            pending_chars.push_back(c);
        end
        for (int k = nd - 1; k >= 0; k--) begin
            c.character = CHAR_ZERO + 8'(digs[k]);
            c.last = (k == 0);
            pending_chars.push_back(c);
        end
    endfunction

    function automatic void queue_literal_text(input string txt);
        t_out_char c;
        for (int i = 0; i < txt.len(); i++) begin
            c.character = txt[i];
            c.last = (i == txt.len() - 1);
            pending_chars.push_back(c);
        end
    endfunction

    function automatic logic [31:0] rand_word();
        logic [31:0] p10 [10];
        int          k;
        logic [31:0] w;
        p10 = '{32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
                32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000};
        k = $urandom_range(9);
        case ($urandom_range(7))
            0: w = $urandom_range(9);
            1: w = $urandom % p10[k];
            2: w = p10[k] + $urandom_range(2) - 32'd1;
            3: w = 32'hFFFF_FFFF - $urandom_range(1000);
            4: w = 32'h8000_0000 + $urandom_range(2) - 32'd1;
            5: w = 32'd0 - p10[k];
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic send_word(input logic [31:0] word, input string txt);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_value_word <= word;
        do @(posedge i_clk); while (!o_ready);
        if (txt.len() != 0) begin
            queue_literal_text(txt);
        end else begin
            queue_decimal_text(word, signed_mode_q);
        end
    endtask

    task automatic set_signed_mode(input logic mode);
        i_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        signed_mode_q = mode;
    endtask

    // Receiver side: random stalls, plus one long hold-off on request.
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected transfer: character %h last %b", o_character, o_last);
                error_count++;
            end else begin
                next_char = pending_chars.pop_front();
                if (o_character !== next_char.character) begin
                    $error("character: expected %h actual %h",
                           next_char.character, o_character);
                    error_count++;
                end
                if (o_last !== next_char.last) begin
                    $error("last: expected %b actual %b", next_char.last, o_last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        i_valid <= 1'b0;
        i_value_word <= '0;
        signed_mode_q = 1'b0;
        error_count = 0;
        stall_cycles = 0;
        hold_req = 1'b0;
        send_idle_pct = 12;
        recv_idle_pct = 75;

        dir_rows = '{
            '{1'b0, 32'd0},          '{1'b0, 32'd1},          '{1'b0, 32'd9},
            '{1'b0, 32'd10},         '{1'b0, 32'hFFFF_FFFF},  '{1'b0, 32'h8000_0000},
            '{1'b0, 32'd999999999},  '{1'b0, 32'd1000000000},
            '{1'b1, 32'd0},          '{1'b1, 32'hFFFF_FFFF},  '{1'b1, 32'h8000_0000},
            '{1'b1, 32'h7FFF_FFFF},  '{1'b1, 32'h8000_0001},  '{1'b1, 32'hFFFF_FFF6},
            '{1'b1, 32'd12345},      '{1'b0, 32'hFFFF_FFF6}
        };
        dir_text = '{
            "0", "1", "9", "", "4294967295", "2147483648", "", "",
            "0", "-1", "-2147483648", "2147483647", "", "", "", ""
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (i == 0 || dir_rows[i].mode != signed_mode_q) begin
                set_signed_mode(dir_rows[i].mode);
            end
            send_word(dir_rows[i].word, dir_text[i]);
        end

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 12; recv_idle_pct = 75; end
                1: begin send_idle_pct = 75; recv_idle_pct = 12; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 0) begin
                    set_signed_mode(1'b1);
                    if (ph == 2) hold_req = 1'b1;
                end else if (n == PHASE_ITEMS / 2) begin
                    set_signed_mode(1'b0);
                end
                send_word(rand_word(), "");
            end
        end

        i_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
